// File: hdl/mfv_pkg.sv
// Shared types for the most frequent value finder.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mfv_pkg;

    typedef logic signed [31:0] code_t;
    typedef logic [8:0]         count_t;

    localparam int unsigned COUNT_MAX = 511;

    typedef struct packed {
        logic accept;
        logic start;
        logic rd_outer;
        logic ld_cand;
        logic rd_inner;
        logic cmp_best;
        logic load_out;
    } mfv_cmd_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic out_busy;
    } mfv_status_t;

endpackage

// File: hdl/mfv_stream_if.sv
// Valid/ready channels for codes in and results out.
// Depends on mfv_pkg for the payload types.
interface mfv_code_if;
    logic               valid;
    logic               ready;
    mfv_pkg::code_t     code_value;
    logic               is_last;

    modport source (output valid, output code_value, output is_last, input ready);
    modport sink   (input valid, input code_value, input is_last, output ready);
endinterface

interface mfv_result_if;
    logic               valid;
    logic               ready;
    mfv_pkg::code_t     mode_value;
    mfv_pkg::count_t    mode_count;
    logic               overflowed;

    modport source (output valid, output mode_value, output mode_count, output overflowed,
                    input ready);
    modport sink   (input valid, input mode_value, input mode_count, input overflowed,
                    output ready);
endinterface

// File: hdl/mfv_ctrl.sv
// Sequencer for code loading and the quadratic occurrence search.
// Depends on mfv_pkg for the command and status structs.
module mfv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  mfv_pkg::mfv_status_t status,
    output mfv_pkg::mfv_cmd_t    cmd
);
    import mfv_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ORD   = 3'd1;
    localparam logic [2:0] ST_OLD   = 3'd2;
    localparam logic [2:0] ST_INNER = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_CMP   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_last)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_ORD;
                end
            end
            ST_ORD:
            begin
                cmd.rd_outer = 1'b1;
                state_next   = ST_OLD;
            end
            ST_OLD:
            begin
                cmd.ld_cand = 1'b1;
                state_next  = ST_INNER;
            end
            ST_INNER:
            begin
                cmd.rd_inner = 1'b1;
                if (status.j_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_best = 1'b1;
                state_next   = status.i_last ? ST_FIN : ST_ORD;
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/mfv_dp.sv
// Code store, index counters, occurrence counter, best tracker and result register.
// Depends on mfv_pkg; driven by mfv_ctrl through command and status structs.
module mfv_dp #(
    parameter int unsigned MAX_CODES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mfv_pkg::mfv_cmd_t    cmd,
    output mfv_pkg::mfv_status_t status,
    input  mfv_pkg::code_t       code_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mfv_pkg::code_t       mode_value,
    output mfv_pkg::count_t      mode_count,
    output logic                 overflowed
);
    import mfv_pkg::*;

    localparam int unsigned AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
    localparam int unsigned CW = $clog2(MAX_CODES + 1);
    localparam int unsigned XW = (CW > 9) ? CW : 9;

    code_t            mem [0:MAX_CODES-1];
    code_t            rd_reg;
    code_t            cand_reg;
    code_t            best_val_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    occ_reg;
    logic [CW-1:0]    best_cnt_reg;
    logic [AW-1:0]    i_reg;
    logic [AW-1:0]    j_reg;
    logic             pend_reg;
    logic             ovf_reg;
    logic             out_valid_reg;
    code_t            out_val_reg;
    count_t           out_cnt_reg;
    logic             out_ovf_reg;
    logic             full;
    logic             wr_en;
    logic [AW-1:0]    raddr;
    logic [CW-1:0]    last_idx;
    logic [XW-1:0]    best_x;
    count_t           best_sat;

    assign full     = (cnt_reg == CW'(MAX_CODES));
    assign wr_en    = cmd.accept && !full;
    assign raddr    = cmd.rd_outer ? i_reg : j_reg;
    assign last_idx = cnt_reg - CW'(1);
    assign best_x   = XW'(best_cnt_reg);
    assign best_sat = (best_x > XW'(COUNT_MAX)) ? count_t'(COUNT_MAX) : best_x[8:0];

    assign status.i_last   = (CW'(i_reg) == last_idx);
    assign status.j_last   = (CW'(j_reg) == last_idx);
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign mode_value = out_val_reg;
    assign mode_count = out_cnt_reg;
    assign overflowed = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[AW-1:0]] <= code_value;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_cand)
        begin
            cand_reg <= rd_reg;
        end
        if (cmd.cmp_best && (occ_reg > best_cnt_reg))
        begin
            best_val_reg <= cand_reg;
        end
        if (cmd.load_out)
        begin
            out_val_reg <= best_val_reg;
            out_cnt_reg <= best_sat;
            out_ovf_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            occ_reg       <= '0;
            best_cnt_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.rd_inner;
            priority if (cmd.load_out)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.accept)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (cmd.start)
            begin
                i_reg        <= '0;
                best_cnt_reg <= '0;
            end
            else if (cmd.cmp_best)
            begin
                i_reg <= i_reg + AW'(1);
                if (occ_reg > best_cnt_reg)
                begin
                    best_cnt_reg <= occ_reg;
                end
            end
            priority if (cmd.ld_cand)
            begin
                occ_reg <= '0;
                j_reg   <= '0;
            end
            else
            begin
                if (cmd.rd_inner)
                begin
                    j_reg <= j_reg + AW'(1);
                end
                if (pend_reg && (rd_reg == cand_reg))
                begin
                    occ_reg <= occ_reg + CW'(1);
                end
            end
            priority if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/most_frequent_value_finder_top.sv
// Codes are taken one a cycle while the block is idle and written to a store of MAX_CODES
// entries; codes past a full store are dropped and flagged. The request carrying is_last
// starts the search: for each of the n stored codes the single read port of the store sweeps
// all n entries. The result is held in an output register, and no code is taken during the
// search or while a new result waits for the previous one.
// Top level of the most frequent value finder; depends on mfv_pkg, the channel
// interfaces, mfv_ctrl and mfv_dp.
module most_frequent_value_finder_top #(
    parameter int unsigned MAX_CODES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    mfv_code_if.sink        codes,
    mfv_result_if.source    result
);
    import mfv_pkg::*;

    mfv_cmd_t    cmd;
    mfv_status_t status;
    logic        in_ready;
    logic        out_valid;
    code_t       mode_value;
    count_t      mode_count;
    logic        overflowed;

    mfv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (codes.valid),
        .in_last  (codes.is_last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mfv_dp #(
        .MAX_CODES (MAX_CODES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .code_value (codes.code_value),
        .out_valid  (out_valid),
        .out_ready  (result.ready),
        .mode_value (mode_value),
        .mode_count (mode_count),
        .overflowed (overflowed)
    );

    assign codes.ready       = in_ready;
    assign result.valid      = out_valid;
    assign result.mode_value = mode_value;
    assign result.mode_count = mode_count;
    assign result.overflowed = overflowed;

endmodule
